// ===== hdl/triangle_coverage_gouraud_defines.svh =====
// Assertion macros shared by the triangle coverage and shading block.
`ifndef TRIANGLE_COVERAGE_GOURAUD_DEFINES_SVH
`define TRIANGLE_COVERAGE_GOURAUD_DEFINES_SVH
`ifndef SYNTHESIS
`define TCG_ASSERT(lbl, ck, rstn, prop) \
  lbl: assert property (@(posedge ck) disable iff (!(rstn)) prop) \
    else $error("triangle shading check failed");
`define TCG_ASSERT_NR(lbl, ck, prop) \
  lbl: assert property (@(posedge ck) prop) else $error("triangle shading check failed");
`else
`define TCG_ASSERT(lbl, ck, rstn, prop)
`define TCG_ASSERT_NR(lbl, ck, prop)
`endif
`endif

// ===== hdl/tcg_pkg.sv =====
// Shared types and constants of the triangle coverage and shading block.
`timescale 1ns / 1ps
`default_nettype none
package tcg_pkg;

  localparam int PIX_W   = 9;
  localparam int CRD_W   = 16;
  localparam int COL_W   = 24;
  localparam int TDATA_W = 80;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_PIXEL = 1'b1;
  localparam logic KIND_BOX   = 1'b0;
  localparam logic KIND_PIXEL = 1'b1;
  localparam logic [1:0] SEL_LAST = 2'd2;

  localparam int FIFO_AW    = 2;
  localparam int FIFO_DEPTH = 1 << FIFO_AW;

  // Edge i runs from vertex A_IDX[i] to vertex C_IDX[i].
  localparam int A_IDX [3] = '{1, 2, 0};
  localparam int C_IDX [3] = '{2, 0, 1};

  typedef struct packed {
    logic                   kind;
    logic [PIX_W-1:0]       px;
    logic [PIX_W-1:0]       py;
    logic [2:0][CRD_W-1:0]  vx;
    logic [2:0][CRD_W-1:0]  vy;
    logic [2:0][COL_W-1:0]  col;
  } job_t;

  typedef struct packed {
    logic             kind;
    logic             cov;
    logic [PIX_W-1:0] px;
    logic [PIX_W-1:0] py;
    logic [PIX_W-1:0] min_x;
    logic [PIX_W-1:0] max_x;
    logic [PIX_W-1:0] min_y;
    logic [PIX_W-1:0] max_y;
  } meta_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_stat_t;

endpackage
`default_nettype wire

// ===== hdl/tcg_front.sv =====
// Front end: takes input beats, keeps the three vertices and issues jobs.
`timescale 1ns / 1ps
`default_nettype none
module tcg_front (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  input  wire logic                        in_tuser,
  input  wire logic [tcg_pkg::TDATA_W-1:0] in_tdata,
  input  wire tcg_pkg::fifo_stat_t         stat,
  output logic                             push,
  output tcg_pkg::job_t                    job
);

  logic [tcg_pkg::CRD_W-1:0] corner_x_r [3];
  logic [tcg_pkg::CRD_W-1:0] corner_y_r [3];
  logic [tcg_pkg::COL_W-1:0] corner_c_r [3];
  logic [tcg_pkg::CRD_W-1:0] corner_x_nxt [3];
  logic [tcg_pkg::CRD_W-1:0] corner_y_nxt [3];
  logic [tcg_pkg::COL_W-1:0] corner_c_nxt [3];
  logic       accept;
  logic [1:0] sel;

  assign in_tready = !stat.full;
  assign accept    = in_tvalid && in_tready;
  assign sel       = in_tdata[1:0];

  always_comb begin
    corner_x_nxt = corner_x_r;
    corner_y_nxt = corner_y_r;
    corner_c_nxt = corner_c_r;
    if (accept && in_tuser == tcg_pkg::FUNC_LOAD && sel <= tcg_pkg::SEL_LAST) begin
      corner_x_nxt[sel] = in_tdata[17:2];
      corner_y_nxt[sel] = in_tdata[33:18];
      corner_c_nxt[sel] = in_tdata[57:34];
    end
    push     = accept && (in_tuser == tcg_pkg::FUNC_PIXEL || sel == tcg_pkg::SEL_LAST);
    job.kind = (in_tuser == tcg_pkg::FUNC_PIXEL) ? tcg_pkg::KIND_PIXEL : tcg_pkg::KIND_BOX;
    job.px   = in_tdata[66:58];
    job.py   = in_tdata[75:67];
    for (int i = 0; i < 3; i++) begin
      job.vx[i]  = corner_x_nxt[i];
      job.vy[i]  = corner_y_nxt[i];
      job.col[i] = corner_c_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        corner_x_r[i] <= '0;
        corner_y_r[i] <= '0;
        corner_c_r[i] <= '0;
      end
    end else begin
      corner_x_r <= corner_x_nxt;
      corner_y_r <= corner_y_nxt;
      corner_c_r <= corner_c_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/tcg_fifo.sv =====
// Short job queue between the front end and the shading pipeline.
`timescale 1ns / 1ps
`default_nettype none
module tcg_fifo (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire tcg_pkg::job_t wr_job,
  input  wire logic          pop,
  output tcg_pkg::job_t      rd_job,
  output tcg_pkg::fifo_stat_t stat
);

  tcg_pkg::job_t                 mem_r [tcg_pkg::FIFO_DEPTH];
  logic [tcg_pkg::FIFO_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [tcg_pkg::FIFO_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [tcg_pkg::FIFO_AW:0]     count_r, count_nxt;
  logic do_push, do_pop;

  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == (tcg_pkg::FIFO_AW+1)'(tcg_pkg::FIFO_DEPTH));
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rd_job     = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + (do_push ? 1'b1 : 1'b0);
    rd_ptr_nxt = rd_ptr_r + (do_pop ? 1'b1 : 1'b0);
    count_nxt  = count_r + (do_push ? 1'b1 : 1'b0) - (do_pop ? 1'b1 : 1'b0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_job;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/tcg_back.sv =====
// Shading pipeline: box, edge functions, coverage, weighted colors and division.
`timescale 1ns / 1ps
`default_nettype none
module tcg_back #(
  parameter int IMAGE_SIZE = 512,
  parameter int FRAC_BITS  = 4
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire tcg_pkg::fifo_stat_t         stat,
  input  wire tcg_pkg::job_t               rd_job,
  output logic                             pop,
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  output logic                             out_tuser,
  output logic [tcg_pkg::TDATA_W-1:0]      out_tdata
);

  localparam int PW = tcg_pkg::PIX_W + FRAC_BITS + 1;
  localparam int DW = ((PW > tcg_pkg::CRD_W) ? PW : tcg_pkg::CRD_W) + 1;
  localparam int EW = 2 * DW + 1;
  localparam int NW = EW + 12;
  localparam int BW = tcg_pkg::CRD_W + 1;
  localparam logic signed [PW-1:0] M1   = PW'(-(64'sd1 <<< FRAC_BITS));
  localparam logic signed [BW-1:0] CADD = BW'((64'sd1 <<< FRAC_BITS) - 64'sd1);
  localparam logic signed [BW-1:0] LIM  = BW'(IMAGE_SIZE - 1);

  function automatic logic [tcg_pkg::PIX_W-1:0] clamp_pix(input logic signed [BW-1:0] v);
    logic signed [BW-1:0] c;
    begin
      c = v;
      if (v < 0) c = '0;
      else if (v > LIM) c = LIM;
      return c[tcg_pkg::PIX_W-1:0];
    end
  endfunction

  function automatic logic [NW:0] div_step(input logic [NW-1:0] r,
                                           input logic [NW-1:0] sh);
    begin
      if (r >= sh) return {1'b1, r - sh};
      return {1'b0, r};
    end
  endfunction

  logic en;
  assign en  = !out_tvalid || out_tready;
  assign pop = en && !stat.empty;

  // Stage 1: job from the queue.
  logic          v1_r;
  tcg_pkg::job_t j1_r;

  // Stage 2: differences and bounding box.
  logic                  v2_r;
  tcg_pkg::meta_t        m2_r;
  logic [2:0][tcg_pkg::COL_W-1:0] c2_r;
  logic signed [DW-1:0]  dy2_r [3], dx2_r [3], pxd2_r [3], pyd2_r [3];
  logic signed [DW-1:0]  fxd2_r [3], fyd2_r [3];
  logic signed [DW-1:0]  ax2_r, ay2_r;

  // Stage 3: products of the edge functions.
  logic                  v3_r;
  tcg_pkg::meta_t        m3_r;
  logic [2:0][tcg_pkg::COL_W-1:0] c3_r;
  logic signed [2*DW-1:0] pe1_r [3], pe2_r [3], pf1_r [3], pf2_r [3];
  logic signed [2*DW-1:0] pa1_r, pa2_r;

  // Stage 4: edge values, coverage and sign normalization.
  logic                  v4_r;
  tcg_pkg::meta_t        m4_r;
  logic [2:0][tcg_pkg::COL_W-1:0] c4_r;
  logic signed [EW-1:0]  w4_r [3];
  logic [EW-1:0]         a4_r;

  // Stage 5: weight times color.
  logic                  v5_r;
  tcg_pkg::meta_t        m5_r;
  logic [EW-1:0]         a5_r;
  logic signed [EW+8:0]  cp5_r [3][3];

  // Stage 6: channel sums.
  logic                  v6_r;
  tcg_pkg::meta_t        m6_r;
  logic [EW-1:0]         a6_r;
  logic [NW-1:0]         r6_r [3];

  // Division stages, one quotient bit each.
  logic                  vd_r [8];
  tcg_pkg::meta_t        md_r [8];
  logic [EW-1:0]         ad_r [8];
  logic [NW-1:0]         rd_r [8][3];
  logic [7:0]            qd_r [8][3];

  // Combinational values of stages 2, 4 and 6.
  tcg_pkg::meta_t        m2_nxt, m4_nxt;
  logic signed [tcg_pkg::CRD_W-1:0] mnx, mxx, mny, mxy;
  logic signed [PW-1:0]  pxs, pys;
  logic signed [EW-1:0]  e4 [3], f4 [3];
  logic signed [EW-1:0]  area4;
  logic                  cov4;
  logic signed [NW-1:0]  n6 [3];

  always_comb begin
    mnx = signed'(j1_r.vx[0]);
    mxx = signed'(j1_r.vx[0]);
    mny = signed'(j1_r.vy[0]);
    mxy = signed'(j1_r.vy[0]);
    for (int i = 1; i < 3; i++) begin
      if (signed'(j1_r.vx[i]) < mnx) mnx = signed'(j1_r.vx[i]);
      if (signed'(j1_r.vx[i]) > mxx) mxx = signed'(j1_r.vx[i]);
      if (signed'(j1_r.vy[i]) < mny) mny = signed'(j1_r.vy[i]);
      if (signed'(j1_r.vy[i]) > mxy) mxy = signed'(j1_r.vy[i]);
    end
    pxs = signed'(PW'(j1_r.px) << FRAC_BITS);
    pys = signed'(PW'(j1_r.py) << FRAC_BITS);
    m2_nxt      = '0;
    m2_nxt.kind = j1_r.kind;
    if (j1_r.kind == tcg_pkg::KIND_PIXEL) begin
      m2_nxt.px = j1_r.px;
      m2_nxt.py = j1_r.py;
    end else begin
      m2_nxt.min_x = clamp_pix(BW'(mnx) >>> FRAC_BITS);
      m2_nxt.max_x = clamp_pix((BW'(mxx) + CADD) >>> FRAC_BITS);
      m2_nxt.min_y = clamp_pix(BW'(mny) >>> FRAC_BITS);
      m2_nxt.max_y = clamp_pix((BW'(mxy) + CADD) >>> FRAC_BITS);
    end
  end

  always_comb begin
    area4 = EW'(pa1_r) + EW'(pa2_r);
    cov4  = (m3_r.kind == tcg_pkg::KIND_PIXEL) && (area4 != '0);
    for (int i = 0; i < 3; i++) begin
      e4[i] = EW'(pe1_r[i]) + EW'(pe2_r[i]);
      f4[i] = EW'(pf1_r[i]) + EW'(pf2_r[i]);
      if (e4[i] != '0) begin
        if (e4[i][EW-1] != area4[EW-1]) cov4 = 1'b0;
      end else if (f4[i] != '0 && f4[i][EW-1] != area4[EW-1]) begin
        cov4 = 1'b0;
      end
    end
    m4_nxt     = m3_r;
    m4_nxt.cov = cov4;
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      n6[ch] = NW'(cp5_r[ch][0]) + NW'(cp5_r[ch][1]) + NW'(cp5_r[ch][2]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (en) begin
      v1_r <= pop;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      j1_r <= rd_job;

      m2_r <= m2_nxt;
      c2_r <= j1_r.col;
      for (int i = 0; i < 3; i++) begin
        dy2_r[i]  <= DW'(signed'(j1_r.vy[tcg_pkg::A_IDX[i]]))
                   - DW'(signed'(j1_r.vy[tcg_pkg::C_IDX[i]]));
        dx2_r[i]  <= DW'(signed'(j1_r.vx[tcg_pkg::C_IDX[i]]))
                   - DW'(signed'(j1_r.vx[tcg_pkg::A_IDX[i]]));
        pxd2_r[i] <= DW'(pxs) - DW'(signed'(j1_r.vx[tcg_pkg::A_IDX[i]]));
        pyd2_r[i] <= DW'(pys) - DW'(signed'(j1_r.vy[tcg_pkg::A_IDX[i]]));
        fxd2_r[i] <= DW'(M1) - DW'(signed'(j1_r.vx[tcg_pkg::A_IDX[i]]));
        fyd2_r[i] <= DW'(M1) - DW'(signed'(j1_r.vy[tcg_pkg::A_IDX[i]]));
      end
      ax2_r <= DW'(signed'(j1_r.vx[0])) - DW'(signed'(j1_r.vx[1]));
      ay2_r <= DW'(signed'(j1_r.vy[0])) - DW'(signed'(j1_r.vy[1]));

      m3_r <= m2_r;
      c3_r <= c2_r;
      for (int i = 0; i < 3; i++) begin
        pe1_r[i] <= dy2_r[i] * pxd2_r[i];
        pe2_r[i] <= dx2_r[i] * pyd2_r[i];
        pf1_r[i] <= dy2_r[i] * fxd2_r[i];
        pf2_r[i] <= dx2_r[i] * fyd2_r[i];
      end
      pa1_r <= dy2_r[0] * ax2_r;
      pa2_r <= dx2_r[0] * ay2_r;

      // Flip every sign when the triangle winds clockwise so the divisor is positive.
      m4_r <= m4_nxt;
      c4_r <= c3_r;
      for (int i = 0; i < 3; i++) begin
        w4_r[i] <= area4[EW-1] ? -e4[i] : e4[i];
      end
      a4_r <= area4[EW-1] ? unsigned'(-area4) : unsigned'(area4);

      m5_r <= m4_r;
      a5_r <= a4_r;
      for (int ch = 0; ch < 3; ch++) begin
        for (int i = 0; i < 3; i++) begin
          cp5_r[ch][i] <= w4_r[i] * signed'({1'b0, c4_r[i][23-8*ch -: 8]});
        end
      end

      m6_r <= m5_r;
      a6_r <= a5_r;
      for (int ch = 0; ch < 3; ch++) begin
        r6_r[ch] <= n6[ch][NW-1] ? '0 : unsigned'(n6[ch]);
      end
    end
  end

  // Restoring division: a dividend of 256 times the divisor or more leaves every bit set.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 8; k++) vd_r[k] <= 1'b0;
    end else if (en) begin
      vd_r[0] <= v6_r;
      for (int k = 1; k < 8; k++) vd_r[k] <= vd_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    logic [NW:0] st;
    if (en) begin
      md_r[0] <= m6_r;
      ad_r[0] <= a6_r;
      for (int ch = 0; ch < 3; ch++) begin
        st = div_step(r6_r[ch], NW'(a6_r) << 7);
        rd_r[0][ch] <= st[NW-1:0];
        qd_r[0][ch] <= {7'd0, st[NW]};
      end
      for (int k = 1; k < 8; k++) begin
        md_r[k] <= md_r[k-1];
        ad_r[k] <= ad_r[k-1];
        for (int ch = 0; ch < 3; ch++) begin
          st = div_step(rd_r[k-1][ch], NW'(ad_r[k-1]) << (7 - k));
          rd_r[k][ch] <= st[NW-1:0];
          qd_r[k][ch] <= {qd_r[k-1][ch][6:0], st[NW]};
        end
      end
    end
  end

  // Output register.
  logic           ov_r;
  tcg_pkg::meta_t om_r;
  logic [7:0]     oc_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (en) begin
      ov_r <= vd_r[7];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      om_r <= md_r[7];
      for (int ch = 0; ch < 3; ch++) begin
        oc_r[ch] <= md_r[7].cov ? qd_r[7][ch] : 8'd0;
      end
    end
  end

  assign out_tvalid = ov_r;
  assign out_tuser  = om_r.kind;
  assign out_tdata  = {1'b0, om_r.max_y, om_r.min_y, om_r.max_x, om_r.min_x,
                       oc_r[2], oc_r[1], oc_r[0], om_r.py, om_r.px, om_r.cov};

endmodule
`default_nettype wire

// ===== hdl/triangle_coverage_gouraud.sv =====
// Top level of the triangle coverage and Gouraud shading block.
//
// Input stream (in_*): each beat either loads one triangle vertex (in_tuser low) or
// asks for one pixel to be tested and shaded (in_tuser high). Loading vertex 2 yields
// one result beat with the clamped bounding box; loads of vertex 0 or 1 and loads with
// select 3 yield nothing. Every pixel beat yields one result beat with the coverage
// flag and, for a covered pixel, the interpolated red, green and blue.
// Output stream (out_*): out_tuser is low for a box beat and high for a pixel beat.
// Throughput is one beat per clock in both directions while out_tready is high. A
// result passes through the job queue, the job register, five arithmetic stages
// (setup, edge products, coverage, color products, channel sums), eight stages of
// the restoring divider that produce one quotient bit each, and the output register.
// When the receiver holds out_tready low the whole shading pipeline freezes; the
// four-entry job queue keeps in_tready high until it fills, after which the input
// stalls too. No beat is dropped or repeated.
// Reset (rst_n low, synchronous) clears the three stored vertices to zero, empties
// the queue and invalidates every pipeline stage.
`timescale 1ns / 1ps
`default_nettype none
`include "triangle_coverage_gouraud_defines.svh"
module triangle_coverage_gouraud #(
  parameter int IMAGE_SIZE = 512,
  parameter int FRAC_BITS  = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // func
  input  wire logic        in_tuser,
  // vertex_sel[1:0], vertex_x[17:2], vertex_y[33:18], vertex_color[57:34],
  // pixel_x[66:58], pixel_y[75:67], zero fill [79:76]
  input  wire logic [79:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // kind
  output logic             out_tuser,
  // covered[0], out_x[9:1], out_y[18:10], red[26:19], green[34:27], blue[42:35],
  // box_min_x[51:43], box_max_x[60:52], box_min_y[69:61], box_max_y[78:70], zero[79]
  output logic [79:0]      out_tdata
);

  tcg_pkg::fifo_stat_t stat;
  tcg_pkg::job_t       wr_job;
  tcg_pkg::job_t       rd_job;
  logic                push;
  logic                pop;

  // The front end owns the vertex registers so each job carries its own snapshot.
  tcg_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .stat      (stat),
    .push      (push),
    .job       (wr_job)
  );

  tcg_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_job (wr_job),
    .pop    (pop),
    .rd_job (rd_job),
    .stat   (stat)
  );

  tcg_back #(
    .IMAGE_SIZE (IMAGE_SIZE),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .stat       (stat),
    .rd_job     (rd_job),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata)
  );

  // An uncovered pixel carries no color.
  `TCG_ASSERT(a_uncov_black, clk, rst_n, out_tvalid && out_tuser && !out_tdata[0] |-> out_tdata[42:19] == 24'd0)
  // A pixel beat leaves the box fields at zero.
  `TCG_ASSERT(a_pix_no_box, clk, rst_n, out_tvalid && out_tuser |-> out_tdata[78:43] == 36'd0)
  // A box beat leaves the pixel fields at zero.
  `TCG_ASSERT(a_box_no_pix, clk, rst_n, out_tvalid && !out_tuser |-> out_tdata[42:0] == 43'd0)
  // Reset empties the output register.
  `TCG_ASSERT_NR(a_rst_idle, clk, !rst_n |=> !out_tvalid)

endmodule
`default_nettype wire

// ===== tb/triangle_coverage_gouraud_tb.sv =====
// Self-checking testbench for the triangle coverage and Gouraud shading block.
`timescale 1ns / 1ps
`default_nettype none

// Scoreboard: keeps its own copy of the three stored vertices, predicts the result of each
// accepted input beat and checks every result beat against the oldest prediction.
class shade_scoreboard;
  localparam int IMG = 512;
  localparam int FB = 4;

  logic [15:0] cx [3];
  logic [15:0] cy [3];
  logic [23:0] ccol [3];
  logic [80:0] pending [$];   // {tuser, tdata}
  int errors;

  function new();
    for (int i = 0; i < 3; i++) begin
      cx[i] = '0;
      cy[i] = '0;
      ccol[i] = '0;
    end
    errors = 0;
  endfunction

  static function longint fdiv(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && ((n < 0) != (d < 0))) q--;
    return q;
  endfunction

  static function longint clampv(longint v, longint hi);
    if (v < 0) return 0;
    if (v > hi) return hi;
    return v;
  endfunction

  static function longint edge_fn(longint xa, longint ya, longint xc, longint yc,
                                  longint px, longint py);
    return (ya - yc) * px + (xc - xa) * py + xa * yc - xc * ya;
  endfunction

  static function int sgn(longint v);
    return (v > 0) - (v < 0);
  endfunction

  // Notes one accepted input beat and queues its result, if any.
  function void note_input(logic func, logic [79:0] d);
    logic [1:0] sel;
    longint vx [3];
    longint vy [3];
    longint w [3];
    longint area, e, far, n, lo_x, hi_x, lo_y, hi_y, px, py;
    logic [79:0] r;
    logic cov;
    int a, c;
    sel = d[1:0];
    r = '0;
    if (func == tcg_pkg::FUNC_LOAD) begin
      if (sel == 2'd3) return;
      cx[sel] = d[17:2];
      cy[sel] = d[33:18];
      ccol[sel] = d[57:34];
      if (sel != tcg_pkg::SEL_LAST) return;
    end
    for (int i = 0; i < 3; i++) begin
      vx[i] = longint'($signed(cx[i]));
      vy[i] = longint'($signed(cy[i]));
    end
    if (func == tcg_pkg::FUNC_LOAD) begin
      lo_x = vx[0]; hi_x = vx[0]; lo_y = vy[0]; hi_y = vy[0];
      for (int i = 1; i < 3; i++) begin
        if (vx[i] < lo_x) lo_x = vx[i];
        if (vx[i] > hi_x) hi_x = vx[i];
        if (vy[i] < lo_y) lo_y = vy[i];
        if (vy[i] > hi_y) hi_y = vy[i];
      end
      r[51:43] = 9'(clampv(fdiv(lo_x, 1 << FB), IMG - 1));
      r[60:52] = 9'(clampv(-fdiv(-hi_x, 1 << FB), IMG - 1));
      r[69:61] = 9'(clampv(fdiv(lo_y, 1 << FB), IMG - 1));
      r[78:70] = 9'(clampv(-fdiv(-hi_y, 1 << FB), IMG - 1));
      pending.push_back({tcg_pkg::KIND_BOX, r});
      return;
    end
    r[9:1] = d[66:58];
    r[18:10] = d[75:67];
    px = longint'(d[66:58]) << FB;
    py = longint'(d[75:67]) << FB;
    area = edge_fn(vx[1], vy[1], vx[2], vy[2], vx[0], vy[0]);
    cov = (area != 0);
    for (int i = 0; i < 3 && area != 0; i++) begin
      a = (i + 1) % 3;
      c = (i + 2) % 3;
      e = edge_fn(vx[a], vy[a], vx[c], vy[c], px, py);
      w[i] = e;
      if (sgn(e) * sgn(area) < 0) cov = 1'b0;
      else if (e == 0) begin
        // On an edge, keep the pixel only if (-1,-1) is on the opposite vertex's side.
        far = edge_fn(vx[a], vy[a], vx[c], vy[c], -(1 << FB), -(1 << FB));
        if (sgn(far) * sgn(area) < 0) cov = 1'b0;
      end
    end
    if (cov) begin
      if (area < 0) begin
        area = -area;
        for (int i = 0; i < 3; i++) w[i] = -w[i];
      end
      r[0] = 1'b1;
      for (int ch = 0; ch < 3; ch++) begin
        n = 0;
        for (int i = 0; i < 3; i++) n += w[i] * longint'((ccol[i] >> (16 - 8 * ch)) & 8'hFF);
        r[19 + 8 * ch +: 8] = 8'(clampv(fdiv(n, area), 255));
      end
    end
    pending.push_back({tcg_pkg::KIND_PIXEL, r});
  endfunction

  // Checks one accepted result beat against the oldest prediction.
  function void check_result(logic kind, logic [79:0] d);
    logic [80:0] want;
    if (pending.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result beat: kind %0d data %h", kind, d);
      return;
    end
    want = pending.pop_front();
    if (want !== {kind, d}) begin
      errors++;
      if (errors <= 10)
        $display("mismatch: expected kind %0d data %h, got kind %0d data %h",
                 want[80], want[79:0], kind, d);
    end
  endfunction
endclass

module triangle_coverage_gouraud_tb;
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tuser = 1'b0;
  logic [79:0] in_tdata = '0;
  logic out_tready = 1'b0;
  wire in_tready;
  wire out_tvalid;
  wire out_tuser;
  wire [79:0] out_tdata;

  // The phase decides how often each side idles; the hold-off request freezes the receiver.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;

  shade_scoreboard sb = new();

  triangle_coverage_gouraud DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tuser(in_tuser), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tuser(out_tuser),
    .out_tdata(out_tdata)
  );

  always #4 clk = ~clk;

  // Both monitors sample just after the rising edge values settle, using the values that
  // were present at the edge, so predictions and checks do not race with the block.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_input(in_tuser, in_tdata);
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tuser, out_tdata);
  end

  // Receiver: stalls at random by phase; when a hold-off is requested it keeps tready low
  // for a long count of cycles so the job queue fills and the input stalls.
  initial begin
    int cnt;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        out_tready <= 1'b0;
        for (cnt = 0; cnt < 200; cnt++) @(posedge clk);
        hold_done = 1'b1;
      end
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Sends one beat, with random idle cycles before it by phase, and waits for acceptance.
  task automatic send_beat(logic func, logic [79:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= func;
    in_tdata <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic send_vertex(logic [1:0] sel, logic [15:0] x, logic [15:0] y,
                             logic [23:0] col);
    send_beat(tcg_pkg::FUNC_LOAD, {4'b0, 18'($urandom_range(511, 0)), col, y, x, sel});
  endtask

  task automatic send_pixel(logic [8:0] px, logic [8:0] py);
    logic [57:0] junk;
    junk = 58'({$urandom(), $urandom()});
    send_beat(tcg_pkg::FUNC_PIXEL, {4'b0, py, px, junk});
  endtask

  // Random vertex coordinate: mostly inside a small part of the image so triangles cover
  // pixels, sometimes anywhere in the full signed range.
  function automatic logic [15:0] rand_coord();
    if ($urandom_range(9) == 0) return 16'($urandom());
    return 16'($urandom_range(64 * 16, 0) - 16);
  endfunction

  // Loads a random triangle, then shades pixels mostly inside its neighborhood.
  task automatic random_triangle(int npix);
    logic [15:0] xs [3];
    logic [15:0] ys [3];
    int lo_x, lo_y;
    for (int i = 0; i < 3; i++) begin
      xs[i] = rand_coord();
      ys[i] = rand_coord();
      send_vertex(2'(i), xs[i], ys[i], 24'($urandom()));
    end
    if ($urandom_range(7) == 0)
      send_vertex(2'd3, 16'($urandom()), 16'($urandom()), 24'($urandom()));
    lo_x = 0;
    lo_y = 0;
    for (int k = 0; k < npix; k++) begin
      if ($urandom_range(9) == 0) send_pixel(9'($urandom()), 9'($urandom()));
      else send_pixel(9'($urandom_range(66, lo_x)), 9'($urandom_range(66, lo_y)));
    end
  endtask

  task automatic drain();
    int guard;
    in_tvalid <= 1'b0;
    guard = 0;
    while (sb.pending.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (30) @(posedge clk);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: shading with the reset (zero-area) triangle, extremes of the fields,
    // an ignored select, a box beyond the image and pixels on shared edges.
    send_pixel(9'd0, 9'd0);
    send_pixel(9'd511, 9'd511);
    send_vertex(2'd0, 16'h0000, 16'h0000, 24'hFF0000);
    send_vertex(2'd1, 16'h00A0, 16'h0000, 24'h00FF00);
    send_vertex(2'd3, 16'hFFFF, 16'hFFFF, 24'hFFFFFF);
    send_vertex(2'd2, 16'h0000, 16'h00A0, 24'h0000FF);
    send_pixel(9'd0, 9'd0);
    send_pixel(9'd5, 9'd0);
    send_pixel(9'd0, 9'd5);
    send_pixel(9'd3, 9'd3);
    send_pixel(9'd10, 9'd10);
    send_vertex(2'd0, 16'h7FFF, 16'h8000, 24'hFFFFFF);
    send_vertex(2'd1, 16'h8000, 16'h7FFF, 24'h000000);
    send_vertex(2'd2, 16'h0008, 16'h0008, 24'h808080);
    send_pixel(9'd100, 9'd200);
    send_pixel(9'd511, 9'd0);
    // Reversed winding with fractional vertices.
    send_vertex(2'd0, 16'h0013, 16'h0025, 24'h123456);
    send_vertex(2'd1, 16'h0047, 16'h01F9, 24'hFEDCBA);
    send_vertex(2'd2, 16'h0301, 16'h0107, 24'hA5A5A5);
    send_pixel(9'd10, 9'd10);
    send_pixel(9'd20, 9'd15);
    // Collinear vertices give zero area.
    send_vertex(2'd2, 16'h0080, 16'h0080, 24'h777777);
    send_vertex(2'd0, 16'h0000, 16'h0000, 24'h777777);
    send_vertex(2'd1, 16'h0040, 16'h0040, 24'h777777);
    send_pixel(9'd4, 9'd4);
    drain();

    // Random phases: none, sender idle, receiver stall, both.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1) ? 84 : (ph == 3) ? 25 : 0;
      recv_stall_pct = (ph == 2) ? 84 : (ph == 3) ? 25 : 0;
      if (ph == 0) hold_req = 1'b1;
      for (int t = 0; t < 21; t++) random_triangle(int'($urandom_range(12, 4)));
      drain();
    end

    // A prediction still waiting here means a result beat never arrived.
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("DONE: errors detected");
    $finish;
  end
endmodule
`default_nettype wire
